/* rtl/bisc_pkg.sv */
// Package for the 2x2 square cover checker: shared constants, register codes,
// item and result types. No dependencies.
`default_nettype none

package bisc_pkg;

  localparam int CFG_W        = 7;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_RESET    = 64;
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;
  localparam int COORD_W      = 6;
  localparam int CNT_W        = 12;
  localparam int Q_DEPTH      = 2;
  localparam int RES_DEPTH    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic KIND_CORNER  = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic px;
    logic first_col;
    logic first_row;
    logic last_col;
    logic last_row;
  } pix_flags_t;

  typedef struct packed {
    logic pix;
    logic mark;
  } line_entry_t;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] corner_row;
    logic [COORD_W-1:0] corner_col;
    logic [CNT_W-1:0]   square_count;
    logic               covered_ok;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

/* rtl/bisc_if.sv */
// Channel interfaces: pixel words in, result words out, valid/ready handshake.
// Depends on bisc_pkg.
`default_nettype none

interface bisc_pixel_if;
  logic valid;
  logic ready;
  logic pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface bisc_result_if import bisc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [COORD_W-1:0] corner_row;
  logic [COORD_W-1:0] corner_col;
  logic [CNT_W-1:0]   square_count;
  logic               covered_ok;
  logic               last;

  modport source (output valid, output kind, output corner_row, output corner_col,
                  output square_count, output covered_ok, output last, input ready);
  modport sink (input valid, input kind, input corner_row, input corner_col,
                input square_count, input covered_ok, input last, output ready);
endinterface

`default_nettype wire

/* rtl/bisc_fifo.sv */
// Small register queue with push/pop and full/empty flags.
// Used between front and back, and ahead of the result port. No dependencies.
`default_nettype none

module bisc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/bisc_front.sv */
// Front end: accepts pixel words, tracks the raster position and tags each
// pixel with its row, column and edge flags. Depends on bisc_pkg, bisc_if.
`default_nettype none

module bisc_front import bisc_pkg::*; #(
  parameter int RW = 6,
  parameter int CW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clr_i,
  input  logic [RW-1:0] rows_last_i,
  input  logic [CW-1:0] cols_last_i,
  bisc_pixel_if.sink    pixel_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output pix_flags_t    q_flags_o,
  output logic [RW-1:0] q_row_o,
  output logic [CW-1:0] q_col_o
);

  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic          accept;

  assign pixel_i.ready = !q_full_i;
  assign accept        = pixel_i.valid && pixel_i.ready;
  assign q_push_o      = accept;
  assign q_row_o       = row_q;
  assign q_col_o       = col_q;

  always_comb begin
    q_flags_o.px        = pixel_i.pixel;
    q_flags_o.first_col = (col_q == '0);
    q_flags_o.first_row = (row_q == '0);
    q_flags_o.last_col  = (col_q == cols_last_i);
    q_flags_o.last_row  = (row_q == rows_last_i);
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (clr_i) begin
      row_d = '0;
      col_d = '0;
    end else if (accept) begin
      if (!q_flags_o.last_col) begin
        col_d = col_q + 1'b1;
      end else begin
        col_d = '0;
        row_d = q_flags_o.last_row ? '0 : row_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/bisc_back.sv */
// Back end: line buffer of the row above with cover marks, 2x2 window,
// square count, cover check and result words. Depends on bisc_pkg.
`default_nettype none

module bisc_back import bisc_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int RW       = 6,
  parameter int CW       = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clr_i,
  input  logic          q_empty_i,
  input  pix_flags_t    q_flags_i,
  input  logic [RW-1:0] q_row_i,
  input  logic [CW-1:0] q_col_i,
  output logic          q_pop_o,
  input  logic          res_full_i,
  output logic          res_push_o,
  output res_t          res_o
);

  line_entry_t   lb_mem [MAX_COLS];
  line_entry_t   rd_q, tail_q, ent, wdata;
  pix_flags_t    flags_q;
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q, waddr;
  logic          v_q, v_d;
  logic          prev_px_q, prev_px_d;
  logic          up_left_q, up_left_d;
  logic          upml_q, upml_d;
  logic          sq_prev_q, sq_prev_d;
  logic          uncov_q, uncov_d;
  logic          corner_done_q, corner_done_d;
  logic [CNT_W-1:0] count_q, count_d, cnt_nx;
  logic          sq, unc, frame_end, corner_pend, has_res, retire, load, wr_en;

  always_comb begin
    ent = flags_q.last_col ? tail_q : rd_q;
    sq  = v_q && !flags_q.first_row && !flags_q.first_col && flags_q.px &&
          prev_px_q && ent.pix && up_left_q;

    unc = 1'b0;
    if (!flags_q.first_row) begin
      if (!flags_q.first_col && up_left_q && !(upml_q || sq)) begin
        unc = 1'b1;
      end
      if (flags_q.last_col && ent.pix && !(ent.mark || sq)) begin
        unc = 1'b1;
      end
    end
    if (flags_q.last_row) begin
      if (!flags_q.first_col && prev_px_q && !(sq_prev_q || sq)) begin
        unc = 1'b1;
      end
      if (flags_q.last_col && flags_q.px && !sq) begin
        unc = 1'b1;
      end
    end

    cnt_nx      = (sq && (count_q != COUNT_MAX)) ? count_q + 1'b1 : count_q;
    frame_end   = flags_q.last_col && flags_q.last_row;
    corner_pend = sq && !corner_done_q;
    has_res     = corner_pend || frame_end;
    res_push_o  = v_q && has_res && !res_full_i;
    retire      = v_q && (!has_res || (!res_full_i && !(corner_pend && frame_end)));
    load        = !q_empty_i && (!v_q || retire);
    q_pop_o     = load;

    wr_en      = retire && !flags_q.first_col;
    waddr      = col_q - 1'b1;
    wdata.pix  = prev_px_q;
    wdata.mark = sq_prev_q || sq;

    res_o = '0;
    if (corner_pend) begin
      res_o.kind       = KIND_CORNER;
      res_o.corner_row = COORD_W'(row_q);
      res_o.corner_col = COORD_W'(col_q);
    end else begin
      res_o.kind         = KIND_VERDICT;
      res_o.square_count = cnt_nx;
      res_o.covered_ok   = !(uncov_q || unc);
      res_o.last         = 1'b1;
    end
  end

  always_comb begin
    v_d           = v_q;
    prev_px_d     = prev_px_q;
    up_left_d     = up_left_q;
    upml_d        = upml_q;
    sq_prev_d     = sq_prev_q;
    count_d       = count_q;
    uncov_d       = uncov_q;
    corner_done_d = corner_done_q;
    if (load) begin
      v_d = 1'b1;
    end else if (retire) begin
      v_d = 1'b0;
    end
    if (retire) begin
      corner_done_d = 1'b0;
      prev_px_d     = flags_q.px;
      up_left_d     = ent.pix;
      upml_d        = ent.mark || sq;
      sq_prev_d     = sq;
      count_d       = frame_end ? '0 : cnt_nx;
      uncov_d       = frame_end ? 1'b0 : (uncov_q || unc);
    end else if (res_push_o && corner_pend) begin
      corner_done_d = 1'b1;
    end
    if (clr_i) begin
      prev_px_d     = 1'b0;
      up_left_d     = 1'b0;
      upml_d        = 1'b0;
      sq_prev_d     = 1'b0;
      count_d       = '0;
      uncov_d       = 1'b0;
      corner_done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q           <= 1'b0;
      prev_px_q     <= 1'b0;
      up_left_q     <= 1'b0;
      upml_q        <= 1'b0;
      sq_prev_q     <= 1'b0;
      count_q       <= '0;
      uncov_q       <= 1'b0;
      corner_done_q <= 1'b0;
    end else begin
      v_q           <= v_d;
      prev_px_q     <= prev_px_d;
      up_left_q     <= up_left_d;
      upml_q        <= upml_d;
      sq_prev_q     <= sq_prev_d;
      count_q       <= count_d;
      uncov_q       <= uncov_d;
      corner_done_q <= corner_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      lb_mem[waddr] <= wdata;
    end
    if (load) begin
      flags_q <= q_flags_i;
      row_q   <= q_row_i;
      col_q   <= q_col_i;
      rd_q    <= (wr_en && (waddr == q_col_i)) ? wdata : lb_mem[q_col_i];
    end
    if (retire && flags_q.last_col) begin
      tail_q.pix  <= flags_q.px;
      tail_q.mark <= sq;
    end
  end

endmodule

`default_nettype wire

/* rtl/binary_image_square_cover_check_core.sv */
// A corner word passes item queue, window registers, result queue. Throughput:
// one pixel per cycle while the result queue has room; a frame's last pixel
// that completes a square waits (corner and verdict leave one per cycle).
// Reset: asynchronous, clears position, count, flags and queues; the line
// buffer has no clearing pass, since the first row of a frame rewrites it.
// Top level: config registers, front end, queues and back end.
`default_nettype none

module binary_image_square_cover_check_core import bisc_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  bisc_pixel_if.sink           pixel_i,
  bisc_result_if.source        result_o
);

  localparam int RW   = $clog2(MAX_ROWS);
  localparam int CW   = $clog2(MAX_COLS);
  localparam int FW   = $bits(pix_flags_t);
  localparam int QW   = FW + RW + CW;
  localparam int RESW = $bits(res_t);
  localparam int RST_ROWS_LAST = ((CFG_RESET > MAX_ROWS) ? MAX_ROWS : CFG_RESET) - 1;
  localparam int RST_COLS_LAST = ((CFG_RESET > MAX_COLS) ? MAX_COLS : CFG_RESET) - 1;

  function automatic int clamp_last(logic [CFG_W-1:0] v, int hi);
    if (v == '0) begin
      return 0;
    end
    if (int'(v) > hi) begin
      return hi - 1;
    end
    return int'(v) - 1;
  endfunction

  logic [RW-1:0] rows_last_q, rows_last_d;
  logic [CW-1:0] cols_last_q, cols_last_d;

  always_comb begin
    rows_last_d = rows_last_q;
    cols_last_d = cols_last_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROWS: rows_last_d = RW'(clamp_last(cfg_wdata_i, MAX_ROWS));
        REG_COLS: cols_last_d = CW'(clamp_last(cfg_wdata_i, MAX_COLS));
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_last_q <= RW'(RST_ROWS_LAST);
      cols_last_q <= CW'(RST_COLS_LAST);
    end else begin
      rows_last_q <= rows_last_d;
      cols_last_q <= cols_last_d;
    end
  end

  pix_flags_t    f_flags, b_flags;
  logic [RW-1:0] f_row, b_row;
  logic [CW-1:0] f_col, b_col;
  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_rdata;
  logic          res_push, res_full, res_empty;
  res_t          res_w, res_head;
  logic [RESW-1:0] res_rdata;

  bisc_front #(
    .RW (RW),
    .CW (CW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (cfg_we_i),
    .rows_last_i (rows_last_q),
    .cols_last_i (cols_last_q),
    .pixel_i     (pixel_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_flags_o   (f_flags),
    .q_row_o     (f_row),
    .q_col_o     (f_col)
  );

  bisc_fifo #(
    .WIDTH (QW),
    .DEPTH (Q_DEPTH)
  ) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({f_flags, f_row, f_col}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign b_flags = pix_flags_t'(q_rdata[QW-1 -: FW]);
  assign b_row   = q_rdata[CW +: RW];
  assign b_col   = q_rdata[CW-1:0];

  bisc_back #(
    .MAX_COLS (MAX_COLS),
    .RW       (RW),
    .CW       (CW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (cfg_we_i),
    .q_empty_i  (q_empty),
    .q_flags_i  (b_flags),
    .q_row_i    (b_row),
    .q_col_i    (b_col),
    .q_pop_o    (q_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_w)
  );

  bisc_fifo #(
    .WIDTH (RESW),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_w),
    .full_o  (res_full),
    .pop_i   (result_o.valid && result_o.ready),
    .rdata_o (res_rdata),
    .empty_o (res_empty)
  );

  assign res_head              = res_t'(res_rdata);
  assign result_o.valid        = !res_empty;
  assign result_o.kind         = res_head.kind;
  assign result_o.corner_row   = res_head.corner_row;
  assign result_o.corner_col   = res_head.corner_col;
  assign result_o.square_count = res_head.square_count;
  assign result_o.covered_ok   = res_head.covered_ok;
  assign result_o.last         = res_head.last;

endmodule

`default_nettype wire
